/* hw/rtl/f2h_pkg.sv */
// ----------------------------------------------------------------------------
// f2h_pkg: shared types and constants for the texel single-to-half encoder
// Channel classes, per-stage payload structs and conversion constants.
// ----------------------------------------------------------------------------
package f2h_pkg;

  localparam int unsigned NUM_CH    = 4;
  localparam int unsigned SGL_W     = 32;
  localparam int unsigned HALF_W    = 16;

  localparam logic [9:0]  EXP_SHIFT = 10'd112;        // single bias minus half bias
  localparam logic signed [9:0] SUB_LIMIT = -10'sd10;
  localparam logic signed [9:0] EXP_INF   = 10'sd31;
  localparam logic signed [9:0] SUB_SHIFT_BASE = 10'sd14;
  localparam logic [14:0] HALF_INF  = 15'h7c00;

  // result class of one channel
  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_SUB,
    CLS_NORM,
    CLS_INF
  } f2h_cls_t;

  // after decode
  typedef struct packed {
    logic       sign;
    f2h_cls_t   cls;
    logic [4:0] shamt;
    logic [4:0] exp;
    logic [23:0] mant;
  } f2h_dec_t;

  // after alignment
  typedef struct packed {
    logic       sign;
    f2h_cls_t   cls;
    logic [4:0] exp;
    logic [9:0] hm;
    logic       rnd;
  } f2h_shf_t;

endpackage

/* hw/rtl/f2h_decode.sv */
// ----------------------------------------------------------------------------
// f2h_decode: stage 1 of one channel
// Rebias the exponent, classify the result and compute the subnormal shift.
// ----------------------------------------------------------------------------
module f2h_decode (
  input  logic                  clk,
  input  logic                  en,
  input  logic [31:0]           bits_in,
  output f2h_pkg::f2h_dec_t     dec_r
);
  import f2h_pkg::*;

  logic signed [9:0] e;
  f2h_dec_t          dec_nxt;

  always_comb begin
    e = $signed({2'b00, bits_in[30:23]} - EXP_SHIFT);
    dec_nxt.sign  = bits_in[31];
    dec_nxt.mant  = {1'b1, bits_in[22:0]};
    dec_nxt.exp   = e[4:0];
    dec_nxt.shamt = 5'(SUB_SHIFT_BASE - e);
    if (e < SUB_LIMIT) begin
      dec_nxt.cls = CLS_ZERO;
    end else if (e <= 10'sd0) begin
      dec_nxt.cls = CLS_SUB;
    end else if (e >= EXP_INF) begin
      dec_nxt.cls = CLS_INF;
    end else begin
      dec_nxt.cls = CLS_NORM;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec_r <= dec_nxt;
    end
  end

endmodule

/* hw/rtl/f2h_shift.sv */
// ----------------------------------------------------------------------------
// f2h_shift: stage 2 of one channel
// Align the mantissa to the half format and pick the rounding bit.
// ----------------------------------------------------------------------------
module f2h_shift (
  input  logic                  clk,
  input  logic                  en,
  input  f2h_pkg::f2h_dec_t     dec_in,
  output f2h_pkg::f2h_shf_t     shf_r
);
  import f2h_pkg::*;

  logic [23:0] sub_hm;
  logic [23:0] sub_rb;
  f2h_shf_t    shf_nxt;

  always_comb begin
    sub_hm = dec_in.mant >> dec_in.shamt;
    sub_rb = dec_in.mant >> (dec_in.shamt - 5'd1);
    shf_nxt.sign = dec_in.sign;
    shf_nxt.cls  = dec_in.cls;
    shf_nxt.exp  = dec_in.exp;
    if (dec_in.cls == CLS_SUB) begin
      shf_nxt.hm  = sub_hm[9:0];
      shf_nxt.rnd = sub_rb[0];
    end else begin
      shf_nxt.hm  = dec_in.mant[22:13];
      shf_nxt.rnd = dec_in.mant[12];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      shf_r <= shf_nxt;
    end
  end

endmodule

/* hw/rtl/f2h_round.sv */
// ----------------------------------------------------------------------------
// f2h_round: stage 3 of one channel
// Add the rounding bit and assemble the half-precision pattern.
// ----------------------------------------------------------------------------
module f2h_round (
  input  logic                  clk,
  input  logic                  en,
  input  f2h_pkg::f2h_shf_t     shf_in,
  output logic [15:0]           half_r
);
  import f2h_pkg::*;

  logic [14:0] mag;
  logic [15:0] half_nxt;

  always_comb begin
    // a mantissa carry runs into the exponent; exponent 30 carries to infinity
    case (shf_in.cls)
      CLS_ZERO: mag = 15'd0;
      CLS_SUB:  mag = {5'd0, shf_in.hm} + {14'd0, shf_in.rnd};
      CLS_NORM: mag = {shf_in.exp, shf_in.hm} + {14'd0, shf_in.rnd};
      CLS_INF:  mag = HALF_INF;
      default:  mag = HALF_INF;
    endcase
    half_nxt = {shf_in.sign, mag};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      half_r <= half_nxt;
    end
  end

endmodule

/* hw/rtl/rgba_float_to_half_encoder.sv */
// ----------------------------------------------------------------------------
// rgba_float_to_half_encoder: RGBA single-to-half texel encoder
// Each request passes the decode, align and round stage registers before out_tvalid.
// Throughput one texel per cycle while out_tready stays high; three stages: decode, align, round.
// Stalls back up stage by stage with no loss or repeat of requests.
// Synchronous active-low reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module rgba_float_to_half_encoder (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [127:0]  in_tdata,   // red_bits, green_bits, blue_bits, alpha_bits
  input  logic          in_tlast,   // last_texel
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [63:0]   out_tdata,  // red_half, green_half, blue_half, alpha_half
  output logic          out_tlast   // last_out
);
  import f2h_pkg::*;

  logic v1_r, v2_r, v3_r;
  logic v1_nxt, v2_nxt, v3_nxt;
  logic rdy1, rdy2, rdy3;
  logic last1_r, last2_r, last3_r;

  f2h_dec_t    dec_s [NUM_CH];
  f2h_shf_t    shf_s [NUM_CH];
  logic [15:0] half_s [NUM_CH];

  assign rdy3 = !v3_r || out_tready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tready = rdy1;

  // advance a stage when the next one frees up, otherwise hold
  always_comb begin
    v1_nxt = rdy1 ? in_tvalid : v1_r;
    v2_nxt = rdy2 ? v1_r : v2_r;
    v3_nxt = rdy3 ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      last1_r <= in_tlast;
    end
    if (rdy2) begin
      last2_r <= last1_r;
    end
    if (rdy3) begin
      last3_r <= last2_r;
    end
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    f2h_decode u_decode (
      .clk     (clk),
      .en      (rdy1),
      .bits_in (in_tdata[c*SGL_W +: SGL_W]),
      .dec_r   (dec_s[c])
    );

    f2h_shift u_shift (
      .clk    (clk),
      .en     (rdy2),
      .dec_in (dec_s[c]),
      .shf_r  (shf_s[c])
    );

    f2h_round u_round (
      .clk    (clk),
      .en     (rdy3),
      .shf_in (shf_s[c]),
      .half_r (half_s[c])
    );

    assign out_tdata[c*HALF_W +: HALF_W] = half_s[c];
  end

  assign out_tvalid = v3_r;
  assign out_tlast  = last3_r;

`ifndef SYNTH
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v1_r)
    else $error("accepted request did not reach stage 1");

  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !out_tready && v2_r) |=> (v2_r && $stable(shf_s[0]) && $stable(last2_r)))
    else $error("stage 2 request changed during stall");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !rdy2) |=> (v1_r && $stable(dec_s[0]) && $stable(last1_r)))
    else $error("stage 1 request changed during stall");

  a_inf_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tdata[30:23] == 8'hff) |=> (dec_s[0].cls == CLS_INF))
    else $error("all-ones exponent not classed as infinity");
`endif

endmodule

/* tb/tb_rgba_float_to_half_encoder.sv */
// ----------------------------------------------------------------------------
// tb_rgba_float_to_half_encoder: self-checking bench for the texel encoder
// Streams RGBA texels of single-precision words through the block and checks
// every half-precision result and its last flag against an in-bench model.
// Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb_rgba_float_to_half_encoder;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_TEXELS = 1600;
  localparam int unsigned REPORT_MAX = 10;
  localparam logic [15:0] HALF_INF_BITS = 16'h7c00;

  typedef struct packed {
    logic             last;
    logic [3:0][31:0] bits;   // red, green, blue, alpha from the low end up
  } texel_t;

  typedef struct packed {
    logic             last;
    logic [3:0][15:0] half;   // red, green, blue, alpha from the low end up
  } half_texel_t;

  class half_texel_checker;
    half_texel_t expected_halves[$];
    int unsigned mismatches;
    string       ch_name[4] = '{"red", "green", "blue", "alpha"};

    function logic [15:0] half_from_single(logic [31:0] f);
      logic [15:0] sgn;
      logic [23:0] m;
      logic [15:0] hm;
      int          e;
      int          sh;
      sgn = {f[31], 15'b0};
      e   = int'(f[30:23]) - 127 + 15;
      m   = {1'b0, f[22:0]};
      if (e <= 0) begin
        if (e < -10) return sgn;
        // denormal half: shift in the hidden one, round on the last bit out
        m[23] = 1'b1;
        sh = 14 - e;
        hm = 16'(m >> sh);
        if (m[sh-1]) hm = hm + 16'd1;
        return sgn | hm;
      end
      if (e >= 31) return sgn | HALF_INF_BITS;
      hm = 16'(m >> 13);
      if (m[12]) begin
        hm = hm + 16'd1;
        if (hm[10]) begin
          e = e + 1;
          if (e >= 31) return sgn | HALF_INF_BITS;
          return sgn | 16'(e << 10);
        end
      end
      return sgn | 16'(e << 10) | {6'b0, hm[9:0]};
    endfunction

    function void note_texel(texel_t t);
      half_texel_t r;
      r.last = t.last;
      for (int c = 0; c < 4; c++) r.half[c] = half_from_single(t.bits[c]);
      expected_halves.push_back(r);
    endfunction

    function void check_halves(half_texel_t got);
      half_texel_t want;
      if (expected_halves.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: tdata %h tlast %b", got.half, got.last);
        return;
      end
      want = expected_halves.pop_front();
      for (int c = 0; c < 4; c++) begin
        if (got.half[c] !== want.half[c]) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch %s: expected %h got %h", ch_name[c], want.half[c],
                     got.half[c]);
        end
      end
      if (got.last !== want.last) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("mismatch last: expected %b got %b", want.last, got.last);
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic         out_tlast;

  half_texel_checker sb;

  rgba_float_to_half_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // bias exponents toward the subnormal, normal and overflow edges of half
  function automatic logic [31:0] random_single();
    logic [31:0] w;
    int          pick;
    w = $urandom;
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      w[30:23] = 8'($urandom_range(98, 145));
    end else if (pick == 6) begin
      w[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
      if ($urandom_range(0, 2) == 0) w[22:0] = '0;
    end else if (pick == 7) begin
      // land right on or around the rounding bit, sometimes with a full mantissa
      w[30:23] = 8'($urandom_range(100, 143));
      case ($urandom_range(0, 3))
        0: w[12:0] = 13'h1000;
        1: w[12:0] = 13'h0fff;
        2: w[12:0] = 13'h1fff;
        default: w[12:0] = 13'h0000;
      endcase
      if ($urandom_range(0, 1)) w[22:13] = '1;
    end
    return w;
  endfunction

  task automatic send_texel(texel_t t);
    in_tvalid <= 1'b1;
    in_tdata  <= t.bits;
    in_tlast  <= t.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_texel(t);
  endtask

  task automatic idle_input(int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_halves({out_tlast, out_tdata});
  end

  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 9) == 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else begin
        int n;
        n = idle_len();
        if (n > 0) begin
          out_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    texel_t      t;
    int          burst_left;
    logic [31:0] corner_bits[24];
    corner_bits = '{
      32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,  // zeros, infinities
      32'h7fc0_0000, 32'hffff_ffff, 32'h3f80_0000, 32'hbf80_0000,  // NaNs, one
      32'h477f_e000, 32'h477f_efff, 32'h477f_f000, 32'h4780_0000,  // half max and past it
      32'h7f7f_ffff, 32'h3300_0000, 32'h3280_0000, 32'h32ff_ffff,  // tiny: tie up, flush
      32'h387f_ffff, 32'h3800_0000, 32'h3880_0000, 32'h0000_0001,  // denormal to normal
      32'h807f_ffff, 32'h3f80_1000, 32'h3f80_0fff, 32'h477f_ffff   // ties, carry to inf
    };
    sb = new;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // corner values, then again with every value moved one channel lower, wrapping into the texel before
    for (int k = 0; k < 12; k++) begin
      for (int c = 0; c < 4; c++)
        t.bits[c] = (k < 6) ? corner_bits[4*k + c] : corner_bits[(4*(k-6) + c + 1) % 24];
      t.last = k[0];
      idle_input(idle_len());
      send_texel(t);
    end

    for (int unsigned n = 0; n < RANDOM_TEXELS; n++) begin
      for (int c = 0; c < 4; c++) t.bits[c] = random_single();
      t.last = ($urandom_range(0, 15) == 0);
      if (burst_left > 0) begin
        burst_left--;
      end else if ($urandom_range(0, 19) == 0) begin
        burst_left = $urandom_range(10, 40);
      end else begin
        idle_input(idle_len());
      end
      send_texel(t);
    end
    in_tvalid <= 1'b0;

    while (sb.expected_halves.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_halves.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/f2h_pkg.sv
hw/rtl/f2h_decode.sv
hw/rtl/f2h_shift.sv
hw/rtl/f2h_round.sv
hw/rtl/rgba_float_to_half_encoder.sv
tb/tb_rgba_float_to_half_encoder.sv
